### src/mwt_pkg.sv
// ----------------------------------------------------------------------------
// mwt_pkg
// Shared types and constants of the prefix max-weight trie block.
// ----------------------------------------------------------------------------
package mwt_pkg;

   localparam int DEF_NODE_COUNT  = 4096;
   localparam int DEF_ALPHABET    = 26;
   localparam int DEF_WEIGHT_BITS = 20;

   localparam int LETTER_BITS    = 5;
   localparam int IN_WEIGHT_BITS = 20;
   localparam int BEST_BITS      = 21;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [LETTER_BITS-1:0]    letter;
      logic                      first_letter;
      logic                      last_letter;
      logic [IN_WEIGHT_BITS-1:0] entry_weight;
   } req_type;

   typedef struct packed {
      logic signed [BEST_BITS-1:0] best_weight;
      logic                        pool_full;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_STEP
   } state_type;

   typedef struct packed {
      logic clear_write;
      logic accept;
      logic execute;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic item_last;
   } dp_status_type;

endpackage

### src/mwt_ram.sv
// ----------------------------------------------------------------------------
// mwt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/mwt_ctrl.sv
// ----------------------------------------------------------------------------
// mwt_ctrl
// Sequencer: clearing pass after reset, then accept / execute per letter,
// and the valid flag of the result register.
// ----------------------------------------------------------------------------
module mwt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mwt_pkg::ctl_cmd_type   cmd,
   input  mwt_pkg::dp_status_type status
);

   import mwt_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      hold;

   // A last letter waits while the previous result still sits unclaimed.
   assign hold = status.item_last && rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!hold) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd.clear_write = 1'b0;
      cmd.accept      = 1'b0;
      cmd.execute     = 1'b0;
      req_ready       = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_write = 1'b1;
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_STEP: begin
            cmd.execute = !hold;
         end
         default: begin
            cmd.clear_write = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.execute && status.item_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/mwt_datapath.sv
// ----------------------------------------------------------------------------
// mwt_datapath
// Child-link memory, walk cursor, node allocation and the result register.
// ----------------------------------------------------------------------------
module mwt_datapath #(
   parameter int NODE_COUNT  = mwt_pkg::DEF_NODE_COUNT,
   parameter int ALPHABET    = mwt_pkg::DEF_ALPHABET,
   parameter int WEIGHT_BITS = mwt_pkg::DEF_WEIGHT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mwt_pkg::ctl_cmd_type   cmd,
   output mwt_pkg::dp_status_type status,
   input  mwt_pkg::req_type       req_data,
   output mwt_pkg::rsp_type       rsp_data
);

   import mwt_pkg::*;

   localparam int NODE_BITS  = $clog2(NODE_COUNT);
   localparam int USED_BITS  = $clog2(NODE_COUNT + 1);
   localparam int LINK_DEPTH = NODE_COUNT * ALPHABET;
   localparam int ADDR_BITS  = $clog2(LINK_DEPTH);
   localparam int ENTRY_BITS = NODE_BITS + WEIGHT_BITS;
   localparam logic [63:0] BEST_MASK = (64'd1 << (WEIGHT_BITS + 1)) - 64'd1;
   localparam logic [BEST_BITS-1:0] NO_MATCH = BEST_MASK[BEST_BITS-1:0];

   // Each link entry also carries the weight of the child it points to; every
   // node except the root has exactly one incoming link.
   logic [NODE_BITS-1:0]   cursor_ff,        cursor_in;
   logic [WEIGHT_BITS-1:0] cursor_weight_ff, cursor_weight_in;
   logic                   failed_ff,        failed_in;
   logic                   overflow_ff,      overflow_in;
   logic [USED_BITS-1:0]   nodes_used_ff,    nodes_used_in;
   logic [ADDR_BITS-1:0]   clear_ff,         clear_in;
   logic [ADDR_BITS-1:0]   link_addr_ff,     link_addr_in;
   req_type                item_ff,          item_in;
   rsp_type                rsp_ff,           rsp_in;

   logic [NODE_BITS-1:0]   start_cursor;
   logic                   req_letter_ok;
   logic [ADDR_BITS-1:0]   rd_addr;
   logic [ENTRY_BITS-1:0]  rd_entry;
   logic                   wr_en;
   logic [ADDR_BITS-1:0]   wr_addr;
   logic [ENTRY_BITS-1:0]  wr_entry;
   logic                   link_wr;
   logic [ENTRY_BITS-1:0]  link_entry;
   logic [NODE_BITS-1:0]   link_child;
   logic [WEIGHT_BITS-1:0] link_weight;
   logic [WEIGHT_BITS-1:0] item_weight;
   logic                   letter_ok;
   logic                   pool_left;
   logic [NODE_BITS-1:0]   new_node;

   mwt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (LINK_DEPTH)
   ) u_links (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // Read address of the incoming letter.
   assign start_cursor  = req_data.first_letter ? '0 : cursor_ff;
   assign req_letter_ok = int'(req_data.letter) < ALPHABET;
   assign rd_addr       = req_letter_ok
                        ? ADDR_BITS'(start_cursor) * ADDR_BITS'(ALPHABET)
                          + ADDR_BITS'(req_data.letter)
                        : '0;

   assign link_child  = rd_entry[ENTRY_BITS-1:WEIGHT_BITS];
   assign link_weight = rd_entry[WEIGHT_BITS-1:0];
   assign item_weight = WEIGHT_BITS'(item_ff.entry_weight);
   assign letter_ok   = int'(item_ff.letter) < ALPHABET;
   assign pool_left   = nodes_used_ff < USED_BITS'(NODE_COUNT);
   assign new_node    = nodes_used_ff[NODE_BITS-1:0];

   assign wr_en    = cmd.clear_write || link_wr;
   assign wr_addr  = cmd.clear_write ? clear_ff : link_addr_ff;
   assign wr_entry = cmd.clear_write ? '0 : link_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff        <= '0;
         cursor_weight_ff <= '0;
         failed_ff        <= 1'b0;
         overflow_ff      <= 1'b0;
         nodes_used_ff    <= USED_BITS'(1);
         clear_ff         <= '0;
      end else begin
         cursor_ff        <= cursor_in;
         cursor_weight_ff <= cursor_weight_in;
         failed_ff        <= failed_in;
         overflow_ff      <= overflow_in;
         nodes_used_ff    <= nodes_used_in;
         clear_ff         <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      link_addr_ff <= link_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign clear_in = cmd.clear_write ? clear_ff + ADDR_BITS'(1) : clear_ff;

   always_comb begin
      cursor_in        = cursor_ff;
      cursor_weight_in = cursor_weight_ff;
      failed_in        = failed_ff;
      overflow_in      = overflow_ff;
      nodes_used_in    = nodes_used_ff;
      item_in          = item_ff;
      link_addr_in     = link_addr_ff;
      rsp_in           = rsp_ff;
      link_wr          = 1'b0;
      link_entry       = rd_entry;

      if (cmd.accept) begin
         item_in      = req_data;
         link_addr_in = rd_addr;
         if (req_data.first_letter) begin
            cursor_in        = '0;
            cursor_weight_in = '0;
            failed_in        = 1'b0;
            overflow_in      = 1'b0;
         end
      end

      if (cmd.execute) begin
         if (item_ff.func == FUNC_QUERY) begin
            if (!failed_ff) begin
               if (!letter_ok || link_child == '0) begin
                  failed_in = 1'b1;
               end else begin
                  cursor_in        = link_child;
                  cursor_weight_in = link_weight;
               end
            end
         end else if (!overflow_ff && letter_ok) begin
            if (link_child == '0) begin
               if (!pool_left) begin
                  overflow_in = 1'b1;
               end else begin
                  link_wr          = 1'b1;
                  link_entry       = {new_node, item_weight};
                  cursor_in        = new_node;
                  cursor_weight_in = item_weight;
                  nodes_used_in    = nodes_used_ff + USED_BITS'(1);
               end
            end else begin
               cursor_in = link_child;
               if (link_weight < item_weight) begin
                  link_wr          = 1'b1;
                  link_entry       = {link_child, item_weight};
                  cursor_weight_in = item_weight;
               end else begin
                  cursor_weight_in = link_weight;
               end
            end
         end

         if (item_ff.last_letter) begin
            if (item_ff.func == FUNC_QUERY) begin
               rsp_in.best_weight = failed_in ? NO_MATCH : BEST_BITS'(cursor_weight_in);
               rsp_in.pool_full   = 1'b0;
            end else begin
               rsp_in.best_weight = '0;
               rsp_in.pool_full   = overflow_in;
            end
            // The string ends here; the next walk starts at the root.
            cursor_in        = '0;
            cursor_weight_in = '0;
            failed_in        = 1'b0;
            overflow_in      = 1'b0;
         end
      end
   end

   assign status.clear_done = clear_ff == ADDR_BITS'(LINK_DEPTH - 1);
   assign status.item_last  = item_ff.last_letter;
   assign rsp_data          = rsp_ff;

endmodule

### src/prefix_max_weight_trie_core.sv
// ----------------------------------------------------------------------------
// prefix_max_weight_trie_core
// Trie of strings with the largest weight kept at every node; one letter per
// transfer, one result per string.
// ----------------------------------------------------------------------------
// Each letter is handled in ST_IDLE, which issues the read of the child-link
// memory at (cursor, letter), then in ST_STEP, which acts on the registered
// read data and, for an insert, may allocate a node or raise a weight with a
// single write to the same memory. The result of a string is written into the
// output register as ST_STEP executes its last letter; a last letter is held
// in the block while the previous result still waits for its transfer. After
// reset the link memory is cleared one entry per cycle, NODE_COUNT * ALPHABET
// entries (106496 at the default size), with req_ready low throughout.
module prefix_max_weight_trie_core #(
   parameter int NODE_COUNT  = mwt_pkg::DEF_NODE_COUNT,
   parameter int ALPHABET    = mwt_pkg::DEF_ALPHABET,
   parameter int WEIGHT_BITS = mwt_pkg::DEF_WEIGHT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mwt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mwt_pkg::rsp_type rsp_data
);

   import mwt_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   mwt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mwt_datapath #(
      .NODE_COUNT  (NODE_COUNT),
      .ALPHABET    (ALPHABET),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

### src/mwt_checker.sv
// ----------------------------------------------------------------------------
// mwt_checker
// Port-level checks of the trie block, bound to the top level.
// ----------------------------------------------------------------------------
module mwt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input mwt_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mwt_pkg::rsp_type rsp_data
);

   import mwt_pkg::*;

   // A result waiting for its transfer keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The clearing pass keeps the input closed after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input open during clearing pass");

   // Every letter needs a memory read before the next one can be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("letters taken back to back");

   // A new result only follows the transfer of a last letter.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_data.last_letter, 2))
      else $error("result without a last letter");

   // Insert results carry no weight and query results never report a full pool.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.pool_full |-> rsp_data.best_weight == '0)
      else $error("pool full flag on a query result");

endmodule

bind prefix_max_weight_trie_core mwt_checker u_checker (.*);

### test/prefix_max_weight_trie_checker.sv
// ----------------------------------------------------------------------------
// prefix_max_weight_trie_checker
// Watches both channels of the trie core, keeps its own copy of the trie and
// compares every result transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module prefix_max_weight_trie_checker #(
   parameter int NODE_COUNT  = mwt_pkg::DEF_NODE_COUNT,
   parameter int ALPHABET    = mwt_pkg::DEF_ALPHABET,
   parameter int WEIGHT_BITS = mwt_pkg::DEF_WEIGHT_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  mwt_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  mwt_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);

   import mwt_pkg::*;

   localparam int LINK_BITS = $clog2(NODE_COUNT);

   logic [LINK_BITS-1:0]   child_of [NODE_COUNT*ALPHABET];
   logic [WEIGHT_BITS-1:0] weight_of [NODE_COUNT];
   int                     nodes_taken;
   int                     cursor;
   bit                     query_missed;
   bit                     pool_ran_out;
   rsp_type                answers_due [$];
   int                     errors = 0;

   function automatic void restart_walk();
      cursor       = 0;
      query_missed = 1'b0;
      pool_ran_out = 1'b0;
   endfunction

   // Applies one letter to the trie copy; returns 1 when the letter closes a
   // string, with the predicted result in answer.
   function automatic bit walk_letter(input req_type item, output rsp_type answer);
      int                     let_idx;
      int                     slot;
      int                     next_node;
      logic [WEIGHT_BITS-1:0] w;
      let_idx = int'(item.letter);
      w       = item.entry_weight[WEIGHT_BITS-1:0];
      answer  = '0;
      if (item.first_letter)
         restart_walk();
      if (item.func == FUNC_QUERY) begin
         if (!query_missed) begin
            if (let_idx >= ALPHABET) begin
               query_missed = 1'b1;
            end else begin
               next_node = int'(child_of[cursor*ALPHABET + let_idx]);
               if (next_node == 0)
                  query_missed = 1'b1;
               else
                  cursor = next_node;
            end
         end
      end else if (!pool_ran_out && let_idx < ALPHABET) begin
         slot      = cursor*ALPHABET + let_idx;
         next_node = int'(child_of[slot]);
         if (next_node == 0) begin
            if (nodes_taken >= NODE_COUNT) begin
               pool_ran_out = 1'b1;
            end else begin
               next_node            = nodes_taken;
               nodes_taken          = nodes_taken + 1;
               child_of[slot]       = LINK_BITS'(next_node);
               weight_of[next_node] = w;
            end
         end else if (weight_of[next_node] < w) begin
            weight_of[next_node] = w;
         end
         if (!pool_ran_out)
            cursor = next_node;
      end
      if (!item.last_letter)
         return 1'b0;
      if (item.func == FUNC_QUERY) begin
         if (query_missed)
            answer.best_weight = '1;
         else
            answer.best_weight = BEST_BITS'(weight_of[cursor]);
      end else begin
         answer.pool_full = pool_ran_out;
      end
      restart_walk();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type answer;
      rsp_type due;
      if (reset) begin
         for (int i = 0; i < NODE_COUNT*ALPHABET; i++)
            child_of[i] = '0;
         for (int i = 0; i < NODE_COUNT; i++)
            weight_of[i] = '0;
         nodes_taken = 1;
         restart_walk();
         answers_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               errors = errors + 1;
               $error("result transfer with none outstanding: best_weight %0d, pool_full %0d",
                      rsp_data.best_weight, rsp_data.pool_full);
            end else begin
               due = answers_due.pop_front();
               if (rsp_data.best_weight !== due.best_weight) begin
                  errors = errors + 1;
                  $error("best_weight: expected %0d, got %0d",
                         due.best_weight, rsp_data.best_weight);
               end
               if (rsp_data.pool_full !== due.pool_full) begin
                  errors = errors + 1;
                  $error("pool_full: expected %0d, got %0d",
                         due.pool_full, rsp_data.pool_full);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (walk_letter(req_data, answer))
               answers_due.push_back(answer);
         end
      end
      error_count   <= errors;
      pending_count <= answers_due.size();
   end

endmodule

### test/prefix_max_weight_trie_core_tb.sv
// ----------------------------------------------------------------------------
// prefix_max_weight_trie_core_tb
// Drives letters of insert and query strings into the trie core: a directed
// set, random strings, long random inserts, random strings over the grown trie
// and a final run without idling; the checker beside the core judges results.
// ----------------------------------------------------------------------------
module prefix_max_weight_trie_core_tb;
   import mwt_pkg::*;

   localparam int ALPHABET     = DEF_ALPHABET;
   localparam int CLOCK_HALF   = 6;
   localparam int MAX_LEN      = 100;
   localparam int LIB_MAX      = 64;
   localparam int LONG_HOLD    = 400;
   localparam int RUN_LIMIT    = 2_500_000 * 2 * CLOCK_HALF;
   localparam logic [IN_WEIGHT_BITS-1:0] WEIGHT_TOP = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      check_errors;
   int      pending_count;

   bit idle_on   = 1'b1;
   bit hold_long = 1'b0;
   int letters_sent = 0;

   // Scratch string and a library of inserted strings for hitting queries.
   logic [LETTER_BITS-1:0] word_buf [MAX_LEN];
   int                     word_len;
   logic [LETTER_BITS-1:0] lib_word [LIB_MAX][MAX_LEN];
   int                     lib_len  [LIB_MAX];
   int                     lib_count = 0;

   prefix_max_weight_trie_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   prefix_max_weight_trie_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (check_errors),
      .pending_count (pending_count)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin : watchdog
      #RUN_LIMIT;
      $display("FAILURE");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_long = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat (int'($urandom_range(1, 19))) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [LETTER_BITS-1:0] pick_letter(input bit wide);
      int r;
      r = $urandom_range(0, 99);
      if (wide || (r >= 70 && r < 97))
         return LETTER_BITS'($urandom_range(0, ALPHABET-1));
      if (r < 70)
         return LETTER_BITS'($urandom_range(0, 3));
      return LETTER_BITS'($urandom_range(ALPHABET, 31));
   endfunction

   function automatic logic [IN_WEIGHT_BITS-1:0] pick_weight();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)
         return '0;
      if (r < 10)
         return WEIGHT_TOP;
      return IN_WEIGHT_BITS'($urandom);
   endfunction

   function automatic void make_word(input int len, input bit wide);
      word_len = len;
      for (int i = 0; i < len; i++)
         word_buf[i] = pick_letter(wide);
   endfunction

   function automatic void keep_word();
      int slot;
      if (lib_count < LIB_MAX) begin
         slot      = lib_count;
         lib_count = lib_count + 1;
      end else begin
         slot = $urandom_range(0, LIB_MAX-1);
      end
      lib_len[slot] = word_len;
      for (int i = 0; i < word_len; i++)
         lib_word[slot][i] = word_buf[i];
   endfunction

   function automatic void load_prefix(input int slot, input int len);
      word_len = len;
      for (int i = 0; i < len; i++)
         word_buf[i] = lib_word[slot][i];
   endfunction

   // Offers one letter and returns at the edge of its transfer. A gap, when
   // taken, starts at the edge of the previous transfer.
   task automatic send_letter(input logic func, input int letter_code, input bit first,
                              input bit last, input logic [IN_WEIGHT_BITS-1:0] weight);
      req_type     item;
      logic [31:0] junk;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         junk = $urandom;
         req_valid <= 1'b0;
         req_data  <= req_type'(junk[$bits(req_type)-1:0]);
         repeat (int'($urandom_range(1, 19))) @(posedge clock);
      end
      item.func         = func;
      item.letter       = LETTER_BITS'(letter_code);
      item.first_letter = first;
      item.last_letter  = last;
      item.entry_weight = weight;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      letters_sent = letters_sent + 1;
   endtask

   task automatic send_word(input logic func, input logic [IN_WEIGHT_BITS-1:0] weight,
                            input bit first_mark, input bit last_mark, input bit mixed);
      logic kind;
      for (int i = 0; i < word_len; i++) begin
         kind = mixed ? 1'($urandom_range(0, 1)) : func;
         send_letter(kind, int'(word_buf[i]), first_mark && i == 0,
                     last_mark && i == word_len-1, weight);
      end
   endtask

   // Stops offering and waits until every predicted result has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic send_random_string();
      int kind;
      int slot;
      kind = $urandom_range(0, 99);
      if (kind < 40 || lib_count == 0) begin
         make_word($urandom_range(1, 8), 1'b0);
         send_word(FUNC_INSERT, pick_weight(), 1'b1, 1'b1, 1'b0);
         keep_word();
      end else if (kind < 70) begin
         slot = $urandom_range(0, lib_count-1);
         load_prefix(slot, $urandom_range(1, lib_len[slot]));
         if ($urandom_range(0, 4) == 0 && word_len < MAX_LEN) begin
            word_buf[word_len] = pick_letter(1'b0);
            word_len = word_len + 1;
         end
         send_word(FUNC_QUERY, pick_weight(), 1'b1, 1'b1, 1'b0);
      end else if (kind < 78) begin
         make_word($urandom_range(1, 8), 1'b0);
         send_word(FUNC_QUERY, pick_weight(), 1'b1, 1'b1, 1'b0);
      end else if (kind < 85) begin
         slot = $urandom_range(0, lib_count-1);
         load_prefix(slot, lib_len[slot]);
         send_word(FUNC_INSERT, pick_weight(), 1'b1, 1'b1, 1'b0);
      end else if (kind < 90) begin
         // No first mark: the walk still starts where the last string left it.
         make_word($urandom_range(1, 6), 1'b0);
         send_word(1'($urandom_range(0, 1)), pick_weight(), 1'b0, 1'b1, 1'b0);
      end else if (kind < 95) begin
         make_word($urandom_range(2, 6), 1'b0);
         send_word(FUNC_INSERT, pick_weight(), 1'b1, 1'b1, 1'b1);
      end else begin
         // Abandoned string: no last mark, the next first mark restarts it.
         make_word($urandom_range(1, 4), 1'b0);
         send_word(1'($urandom_range(0, 1)), pick_weight(), 1'b1, 1'b0, 1'b0);
      end
   endtask

   initial begin : stimulus
      int stop_at;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed strings; letter 0 is a, 25 is z.
      send_letter(FUNC_INSERT, 0, 1'b1, 1'b1, 20'd1);
      send_letter(FUNC_INSERT, 25, 1'b1, 1'b1, WEIGHT_TOP);
      send_letter(FUNC_QUERY, 0, 1'b1, 1'b1, 20'd0);
      send_letter(FUNC_QUERY, 25, 1'b1, 1'b1, WEIGHT_TOP);
      send_letter(FUNC_INSERT, 0, 1'b1, 1'b0, 20'd5);
      send_letter(FUNC_INSERT, 1, 1'b0, 1'b1, 20'd5);
      send_letter(FUNC_INSERT, 0, 1'b1, 1'b0, 20'd3);
      send_letter(FUNC_INSERT, 1, 1'b0, 1'b1, 20'd3);
      send_letter(FUNC_QUERY, 0, 1'b1, 1'b0, 20'd0);
      send_letter(FUNC_QUERY, 1, 1'b0, 1'b1, 20'd0);
      send_letter(FUNC_INSERT, 2, 1'b1, 1'b1, 20'd0);
      send_letter(FUNC_QUERY, 2, 1'b1, 1'b1, 20'd0);
      // A miss on the first letter; the later letter must not revive the walk.
      send_letter(FUNC_QUERY, 16, 1'b1, 1'b0, 20'd0);
      send_letter(FUNC_QUERY, 0, 1'b0, 1'b1, 20'd0);
      // An out-of-range letter inside an insert is skipped.
      send_letter(FUNC_INSERT, 0, 1'b1, 1'b0, 20'd9);
      send_letter(FUNC_INSERT, 31, 1'b0, 1'b0, 20'd9);
      send_letter(FUNC_INSERT, 1, 1'b0, 1'b1, 20'd9);
      send_letter(FUNC_INSERT, 30, 1'b1, 1'b1, WEIGHT_TOP);
      send_letter(FUNC_QUERY, 26, 1'b1, 1'b1, 20'd0);
      send_letter(FUNC_QUERY, 25, 1'b0, 1'b1, 20'd0);
      send_letter(FUNC_INSERT, 0, 1'b1, 1'b0, 20'd2);
      send_letter(FUNC_QUERY, 1, 1'b0, 1'b1, 20'd0);
      send_letter(FUNC_QUERY, 0, 1'b1, 1'b0, 20'd0);
      send_letter(FUNC_INSERT, 3, 1'b0, 1'b1, 20'd7);
      wait_drained();

      // Random strings in chunks; one chunk runs under a long result hold-off.
      for (int chunk = 0; chunk < 4; chunk++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (chunk == 1)
            hold_long = 1'b1;
         stop_at = letters_sent + 60;
         while (letters_sent < stop_at)
            send_random_string();
      end
      wait_drained();

      // Long random inserts grow deep paths for the queries that follow.
      idle_on = 1'b1;
      for (int s = 0; s < 2; s++) begin
         make_word(MAX_LEN, 1'b1);
         send_word(FUNC_INSERT, pick_weight(), 1'b1, 1'b1, 1'b0);
         keep_word();
      end
      wait_drained();

      // Random strings over the grown trie, old and new paths alike.
      stop_at = letters_sent + 200;
      while (letters_sent < stop_at)
         send_random_string();
      wait_drained();

      idle_on = 1'b0;
      stop_at = letters_sent + 130;
      while (letters_sent < stop_at)
         send_random_string();
      wait_drained();
      repeat (20) @(posedge clock);

      if (check_errors == 0 && pending_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
